FILE: rtl/core/rpdf_pkg.sv
// Shared types, constants and functions of the rectangle pixel packet deframer.
`timescale 1ns / 1ps
package rpdf_pkg;

   // Display size registers and coordinate width.
   localparam int DIM_W = 13;
   localparam logic [DIM_W-1:0] DISPLAY_WIDTH_RESET  = 13'd320;
   localparam logic [DIM_W-1:0] DISPLAY_HEIGHT_RESET = 13'd240;

   // Register indexes of the configuration port.
   localparam logic REG_DISPLAY_WIDTH  = 1'b0;
   localparam logic REG_DISPLAY_HEIGHT = 1'b1;

   // Default widest rectangle that may be drawn.
   localparam int MAX_RECT_WIDTH_DEFAULT = 320;

   // Word queue between the parser and the address unit.
   localparam int QUEUE_DEPTH = 4;

   // Sync word and header layout.
   localparam logic [7:0] SYNC_WORD [0:3] = '{8'h41, 8'h43, 8'h44, 8'h31};
   localparam logic [1:0] SYNC_LAST  = 2'd3;
   localparam logic [2:0] HEADER_LAST = 3'd7;

   // Address and row-base product widths.
   localparam int ADDR_W = 24;
   localparam int PROD_W = 2 * DIM_W;

   // Parser phases; the unused code falls back to sync search.
   typedef enum logic [1:0] {
      PHASE_SYNC   = 2'd0,
      PHASE_HEADER = 2'd1,
      PHASE_PIXELS = 2'd2
   } rpdf_phase_type;

   // One classified word handed from the parser to the address unit.
   typedef struct packed {
      logic             reject;
      logic [DIM_W-1:0] row_abs;
      logic [DIM_W-1:0] col_abs;
      logic [15:0]      color;
      logic             row_end;
      logic             frame_end;
   } rpdf_entry_type;

   // Contents of the multiply stage in the address unit.
   typedef struct packed {
      logic              reject;
      logic [PROD_W-1:0] row_base;
      logic [DIM_W-1:0]  col_abs;
      logic [31:0]       rgba;
      logic              row_end;
      logic              frame_end;
   } rpdf_stage_type;

   // Expand an RGB565 colour to RGBA8888 with opaque alpha.
   function automatic logic [31:0] expand565(input logic [15:0] c);
      logic [4:0] r5;
      logic [5:0] g6;
      logic [4:0] b5;
      logic [7:0] r8;
      logic [7:0] g8;
      logic [7:0] b8;
      r5 = c[15:11];
      g6 = c[10:5];
      b5 = c[4:0];
      r8 = {r5, r5[4:2]};
      g8 = {g6, g6[5:4]};
      b8 = {b5, b5[4:2]};
      return {8'hff, b8, g8, r8};
   endfunction

endpackage

FILE: rtl/core/rpdf_front.sv
// Byte parser: sync hunt, header collection, rectangle check and pixel pairing.
`timescale 1ns / 1ps
module rpdf_front #(
   parameter int MAX_RECT_WIDTH = rpdf_pkg::MAX_RECT_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  data_byte,
   input  logic [rpdf_pkg::DIM_W-1:0]  display_width,
   input  logic [rpdf_pkg::DIM_W-1:0]  display_height,
   output logic                        push_valid,
   output rpdf_pkg::rpdf_entry_type    push_entry
);

   localparam int CW = $clog2(MAX_RECT_WIDTH + 1);
   localparam int DW = rpdf_pkg::DIM_W;

   rpdf_pkg::rpdf_phase_type phase_ff, phase_in;
   logic [1:0]    sync_ff, sync_in;
   logic [2:0]    hcount_ff, hcount_in;
   logic [7:0]    hdr_ff [0:6];
   logic [DW-1:0] left_ff, left_in;
   logic [CW-1:0] cols_ff, cols_in;
   logic [DW-1:0] rows_ff, rows_in;
   logic [CW-1:0] col_cnt_ff, col_cnt_in;
   logic [DW-1:0] row_cnt_ff, row_cnt_in;
   logic [DW-1:0] col_abs_ff, col_abs_in;
   logic [DW-1:0] row_abs_ff, row_abs_in;
   logic [7:0]    low_ff, low_in;
   logic          low_valid_ff, low_valid_in;

   logic [15:0] hdr_left, hdr_top, hdr_cols, hdr_rows;
   logic        rect_ok;
   logic        last_col, last_row;

   // Header fields as they stand when the last header byte arrives.
   assign hdr_left = {hdr_ff[1], hdr_ff[0]};
   assign hdr_top  = {hdr_ff[3], hdr_ff[2]};
   assign hdr_cols = {hdr_ff[5], hdr_ff[4]};
   assign hdr_rows = {data_byte, hdr_ff[6]};

   // The rectangle must be nonzero, narrow enough and inside the display.
   assign rect_ok = (hdr_cols != 16'd0) && (hdr_rows != 16'd0) &&
                    (hdr_cols <= 16'(MAX_RECT_WIDTH)) &&
                    (17'(hdr_left) + 17'(hdr_cols) <= 17'(display_width)) &&
                    (17'(hdr_top) + 17'(hdr_rows) <= 17'(display_height));

   // Position of the pixel being completed within the rectangle.
   assign last_col = ((CW+1)'(col_cnt_ff) + (CW+1)'(1)) == (CW+1)'(cols_ff);
   assign last_row = ((DW+1)'(row_cnt_ff) + (DW+1)'(1)) == (DW+1)'(rows_ff);

   // Next state of the parser and the word it hands on.
   always_comb begin
      phase_in     = phase_ff;
      sync_in      = sync_ff;
      hcount_in    = hcount_ff;
      left_in      = left_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      col_cnt_in   = col_cnt_ff;
      row_cnt_in   = row_cnt_ff;
      col_abs_in   = col_abs_ff;
      row_abs_in   = row_abs_ff;
      low_in       = low_ff;
      low_valid_in = low_valid_ff;
      push_valid   = 1'b0;
      push_entry   = '0;
      if (accept) begin
         case (phase_ff)
            rpdf_pkg::PHASE_HEADER: begin
               if (hcount_ff == rpdf_pkg::HEADER_LAST) begin
                  hcount_in    = '0;
                  left_in      = hdr_left[DW-1:0];
                  cols_in      = hdr_cols[CW-1:0];
                  rows_in      = hdr_rows[DW-1:0];
                  col_cnt_in   = '0;
                  row_cnt_in   = '0;
                  col_abs_in   = hdr_left[DW-1:0];
                  row_abs_in   = hdr_top[DW-1:0];
                  low_valid_in = 1'b0;
                  if (rect_ok) begin
                     phase_in = rpdf_pkg::PHASE_PIXELS;
                  end else begin
                     phase_in          = rpdf_pkg::PHASE_SYNC;
                     sync_in           = '0;
                     push_valid        = 1'b1;
                     push_entry.reject = 1'b1;
                  end
               end else begin
                  hcount_in = hcount_ff + 3'd1;
               end
            end
            rpdf_pkg::PHASE_PIXELS: begin
               if (!low_valid_ff) begin
                  low_in       = data_byte;
                  low_valid_in = 1'b1;
               end else begin
                  low_valid_in         = 1'b0;
                  push_valid           = 1'b1;
                  push_entry.row_abs   = row_abs_ff;
                  push_entry.col_abs   = col_abs_ff;
                  push_entry.color     = {data_byte, low_ff};
                  push_entry.row_end   = last_col;
                  push_entry.frame_end = last_col && last_row;
                  if (last_col) begin
                     col_cnt_in = '0;
                     col_abs_in = left_ff;
                     row_cnt_in = row_cnt_ff + DW'(1);
                     row_abs_in = row_abs_ff + DW'(1);
                     if (last_row) begin
                        phase_in   = rpdf_pkg::PHASE_SYNC;
                        sync_in    = '0;
                        hcount_in  = '0;
                        col_cnt_in = '0;
                        row_cnt_in = '0;
                     end
                  end else begin
                     col_cnt_in = col_cnt_ff + CW'(1);
                     col_abs_in = col_abs_ff + DW'(1);
                  end
               end
            end
            default: begin
               // Sync hunt; a mismatch restarts at one if it is the first sync byte.
               phase_in = rpdf_pkg::PHASE_SYNC;
               if (data_byte == rpdf_pkg::SYNC_WORD[sync_ff]) begin
                  if (sync_ff == rpdf_pkg::SYNC_LAST) begin
                     sync_in   = '0;
                     phase_in  = rpdf_pkg::PHASE_HEADER;
                     hcount_in = '0;
                  end else begin
                     sync_in = sync_ff + 2'd1;
                  end
               end else if (data_byte == rpdf_pkg::SYNC_WORD[0]) begin
                  sync_in = 2'd1;
               end else begin
                  sync_in = 2'd0;
               end
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rpdf_pkg::PHASE_SYNC;
         sync_ff      <= '0;
         hcount_ff    <= '0;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         low_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sync_ff      <= sync_in;
         hcount_ff    <= hcount_in;
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         low_valid_ff <= low_valid_in;
      end
   end

   // Rectangle geometry and pixel data.
   always_ff @(posedge clock) begin
      left_ff    <= left_in;
      cols_ff    <= cols_in;
      rows_ff    <= rows_in;
      col_abs_ff <= col_abs_in;
      row_abs_ff <= row_abs_in;
      low_ff     <= low_in;
   end

   // Header bytes are kept until the last one completes the header.
   always_ff @(posedge clock) begin
      if (accept && (phase_ff == rpdf_pkg::PHASE_HEADER) &&
          (hcount_ff != rpdf_pkg::HEADER_LAST)) begin
         hdr_ff[hcount_ff] <= data_byte;
      end
   end

endmodule

FILE: rtl/core/rpdf_queue.sv
// Short word queue between the parser and the address unit.
`timescale 1ns / 1ps
module rpdf_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rpdf_pkg::rpdf_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     pop_valid,
   output rpdf_pkg::rpdf_entry_type pop_entry
);

   localparam int DEPTH = rpdf_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);

   rpdf_pkg::rpdf_entry_type mem_ff [0:DEPTH-1];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;

   assign full      = (count_ff == CNTW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage of queued words.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/core/rpdf_back.sv
// Address unit: row base multiply, column add, colour expansion and output register.
`timescale 1ns / 1ps
module rpdf_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  rpdf_pkg::rpdf_entry_type           q_entry,
   output logic                               q_pop,
   input  logic [rpdf_pkg::DIM_W-1:0]         display_width,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_event_res,
   output logic [rpdf_pkg::ADDR_W-1:0]        rsp_pixel_address,
   output logic [31:0]                        rsp_pixel_rgba,
   output logic                               rsp_row_end,
   output logic                               rsp_frame_end
);

   localparam int PW = rpdf_pkg::PROD_W;
   localparam int AW = rpdf_pkg::ADDR_W;

   rpdf_pkg::rpdf_stage_type s1_ff, s1_in;
   logic        s1_valid_ff;
   logic        out_valid_ff;
   logic        out_event_ff, out_event_in;
   logic [AW-1:0] out_addr_ff, out_addr_in;
   logic [31:0] out_rgba_ff, out_rgba_in;
   logic        out_row_end_ff, out_row_end_in;
   logic        out_frame_end_ff, out_frame_end_in;
   logic        s2_move, s1_move;
   logic [PW-1:0] addr_sum;

   // Each stage moves on when the one after it is empty or moving.
   assign s2_move = !out_valid_ff || !rsp_stall;
   assign s1_move = !s1_valid_ff || s2_move;
   assign q_pop   = q_valid && s1_move;

   // First stage: row base from the current display width, colour expansion.
   always_comb begin
      s1_in.reject    = q_entry.reject;
      s1_in.row_base  = PW'(q_entry.row_abs) * PW'(display_width);
      s1_in.col_abs   = q_entry.col_abs;
      s1_in.rgba      = q_entry.reject ? 32'd0 : rpdf_pkg::expand565(q_entry.color);
      s1_in.row_end   = q_entry.row_end;
      s1_in.frame_end = q_entry.frame_end;
   end

   // Second stage: add the column; a reject word carries zero fields.
   assign addr_sum = s1_ff.row_base + PW'(s1_ff.col_abs);

   always_comb begin
      out_event_in     = s1_ff.reject;
      out_addr_in      = s1_ff.reject ? '0 : addr_sum[AW-1:0];
      out_rgba_in      = s1_ff.rgba;
      out_row_end_in   = s1_ff.row_end && !s1_ff.reject;
      out_frame_end_in = s1_ff.frame_end && !s1_ff.reject;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_move) begin
            s1_valid_ff <= q_valid;
         end
         if (s2_move) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_ff <= s1_in;
      end
      if (s2_move && s1_valid_ff) begin
         out_event_ff     <= out_event_in;
         out_addr_ff      <= out_addr_in;
         out_rgba_ff      <= out_rgba_in;
         out_row_end_ff   <= out_row_end_in;
         out_frame_end_ff <= out_frame_end_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_res     = out_event_ff;
   assign rsp_pixel_address = out_addr_ff;
   assign rsp_pixel_rgba    = out_rgba_ff;
   assign rsp_row_end       = out_row_end_ff;
   assign rsp_frame_end     = out_frame_end_ff;

endmodule

FILE: rtl/core/rect_pixel_packet_deframer_unit.sv
// A result word passes through the queue, the multiply stage and the output register.
// Throughput: one byte per cycle while the queue is not full; a pixel word every two bytes.
// A four-word queue lets the parser run on while the output is stalled.
// Reset is synchronous: the parser returns to sync hunting, the queue and pipeline empty,
// and the display size returns to 320 by 240. No clearing pass follows reset.
`timescale 1ns / 1ps
module rect_pixel_packet_deframer_unit #(
   parameter int MAX_RECT_WIDTH = rpdf_pkg::MAX_RECT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_event_res,
   output logic [rpdf_pkg::ADDR_W-1:0]       rsp_pixel_address,
   output logic [31:0]                       rsp_pixel_rgba,
   output logic                              rsp_row_end,
   output logic                              rsp_frame_end,
   input  logic                              csr_write_enable,
   input  logic                              csr_index,
   input  logic [rpdf_pkg::DIM_W-1:0]        csr_data
);

   logic [rpdf_pkg::DIM_W-1:0] width_ff, width_in;
   logic [rpdf_pkg::DIM_W-1:0] height_ff, height_in;
   logic                       accept;
   logic                       q_push;
   rpdf_pkg::rpdf_entry_type   q_push_entry;
   logic                       q_full;
   logic                       q_pop;
   logic                       q_valid;
   rpdf_pkg::rpdf_entry_type   q_entry;

   // Display size registers.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rpdf_pkg::REG_DISPLAY_WIDTH:  width_in  = csr_data;
            rpdf_pkg::REG_DISPLAY_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rpdf_pkg::DISPLAY_WIDTH_RESET;
         height_ff <= rpdf_pkg::DISPLAY_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Input words are held off only while the queue is full.
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   rpdf_front #(
      .MAX_RECT_WIDTH(MAX_RECT_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_data_byte),
      .display_width  (width_ff),
      .display_height (height_ff),
      .push_valid     (q_push),
      .push_entry     (q_push_entry)
   );

   rpdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   rpdf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_entry           (q_entry),
      .q_pop             (q_pop),
      .display_width     (width_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_res     (rsp_event_res),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_rgba    (rsp_pixel_rgba),
      .rsp_row_end       (rsp_row_end),
      .rsp_frame_end     (rsp_frame_end)
   );

`ifndef SYNTHESIS
   // The parser never writes into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("word pushed into a full queue");

   // The end of a rectangle is always the end of a row.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_row_end)
      else $error("frame end without row end");

   // A reject word carries no pixel content.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res) |->
      (rsp_pixel_address == '0 && rsp_pixel_rgba == 32'd0 && !rsp_row_end))
      else $error("reject word carries pixel fields");
`endif

endmodule

FILE: dv/rect_pixel_packet_deframer_unit_tb.sv
// Self-checking testbench of the rectangle pixel packet deframer, with its own predictor.
`timescale 1ns / 1ps
module rect_pixel_packet_deframer_unit_tb;

   localparam int MAX_RECT = rpdf_pkg::MAX_RECT_WIDTH_DEFAULT;
   localparam int DW       = rpdf_pkg::DIM_W;

   // One framebuffer write or header reject, as seen on the result port.
   typedef struct packed {
      logic                        reject;
      logic [rpdf_pkg::ADDR_W-1:0] address;
      logic [31:0]                 rgba;
      logic                        row_end;
      logic                        frame_end;
   } fb_write_type;

   // Tracks the parser state, predicts the result words and checks them in order.
   class pixel_write_scoreboard_type;
      rpdf_pkg::rpdf_phase_type phase;
      logic [2:0]       sync_count;
      logic [7:0]       header_bytes [0:7];
      logic [3:0]       header_count;
      logic [15:0]      rect_x, rect_y, rect_w, rect_h;
      logic [15:0]      col, row;
      logic [7:0]       colour_low;
      logic             colour_low_held;
      logic [DW-1:0]    disp_w, disp_h;
      fb_write_type     pending_writes [$];
      int               failures;

      function new();
         disp_w = rpdf_pkg::DISPLAY_WIDTH_RESET;
         disp_h = rpdf_pkg::DISPLAY_HEIGHT_RESET;
         foreach (header_bytes[i]) header_bytes[i] = 8'h00;
         rect_x = 0;
         rect_y = 0;
         rect_w = 0;
         rect_h = 0;
         colour_low = 0;
         failures = 0;
         restart_hunt();
      endfunction

      function void restart_hunt();
         phase = rpdf_pkg::PHASE_SYNC;
         sync_count = 0;
         header_count = 0;
         col = 0;
         row = 0;
         colour_low_held = 0;
      endfunction

      // Widens each RGB565 channel by repeating its top bits; alpha is opaque.
      function logic [31:0] expand_rgb565(logic [15:0] c);
         int red, green, blue;
         red = c[15:11];
         green = c[10:5];
         blue = c[4:0];
         red = (red << 3) | (red >> 2);
         green = (green << 2) | (green >> 4);
         blue = (blue << 3) | (blue >> 2);
         return {8'hff, blue[7:0], green[7:0], red[7:0]};
      endfunction

      // Advances the parser by one accepted input word.
      function void take_byte(logic [7:0] b);
         fb_write_type    w;
         bit              fits, last_col, last_row;
         longint unsigned addr;
         case (phase)
            rpdf_pkg::PHASE_HEADER: begin
               header_bytes[header_count[2:0]] = b;
               header_count++;
               if (header_count >= 8) begin
                  rect_x = {header_bytes[1], header_bytes[0]};
                  rect_y = {header_bytes[3], header_bytes[2]};
                  rect_w = {header_bytes[5], header_bytes[4]};
                  rect_h = {header_bytes[7], header_bytes[6]};
                  col = 0;
                  row = 0;
                  colour_low_held = 0;
                  fits = rect_w != 0 && rect_h != 0 && rect_w <= MAX_RECT &&
                         32'(rect_x) + rect_w <= disp_w && 32'(rect_y) + rect_h <= disp_h;
                  if (fits) begin
                     phase = rpdf_pkg::PHASE_PIXELS;
                  end else begin
                     restart_hunt();
                     w = '0;
                     w.reject = 1'b1;
                     pending_writes.push_back(w);
                  end
               end
            end
            rpdf_pkg::PHASE_PIXELS: begin
               if (!colour_low_held) begin
                  colour_low = b;
                  colour_low_held = 1;
               end else begin
                  colour_low_held = 0;
                  addr = (64'(rect_y) + row) * disp_w + rect_x + col;
                  last_col = 32'(col) + 1 >= rect_w;
                  last_row = 32'(row) + 1 >= rect_h;
                  w.reject = 1'b0;
                  w.address = addr[rpdf_pkg::ADDR_W-1:0];
                  w.rgba = expand_rgb565({b, colour_low});
                  w.row_end = last_col;
                  w.frame_end = last_col && last_row;
                  pending_writes.push_back(w);
                  if (last_col) begin
                     col = 0;
                     row++;
                     if (last_row) restart_hunt();
                  end else begin
                     col++;
                  end
               end
            end
            default: begin
               // A mismatch restarts the hunt, keeping a fresh first sync byte.
               if (b == rpdf_pkg::SYNC_WORD[sync_count[1:0]]) begin
                  sync_count++;
                  if (sync_count >= 4) begin
                     sync_count = 0;
                     phase = rpdf_pkg::PHASE_HEADER;
                     header_count = 0;
                  end
               end else begin
                  sync_count = (b == rpdf_pkg::SYNC_WORD[0]) ? 3'd1 : 3'd0;
               end
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display("%0t: %s expected %h, got %h", $time, name, want, got);
         end
      endfunction

      // Checks one accepted result word against the oldest prediction.
      function void check_write(fb_write_type got);
         fb_write_type want;
         if (pending_writes.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: result word with none predicted: %h", $time, got);
            return;
         end
         want = pending_writes.pop_front();
         compare_field("event_res", want.reject, got.reject);
         compare_field("pixel_address", want.address, got.address);
         compare_field("pixel_rgba", want.rgba, got.rgba);
         compare_field("row_end", want.row_end, got.row_end);
         compare_field("frame_end", want.frame_end, got.frame_end);
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [7:0]                  req_data_byte = 8'h00;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_event_res;
   logic [rpdf_pkg::ADDR_W-1:0] rsp_pixel_address;
   logic [31:0]                 rsp_pixel_rgba;
   logic                        rsp_row_end;
   logic                        rsp_frame_end;
   logic                        csr_write_enable = 1'b0;
   logic                        csr_index = rpdf_pkg::REG_DISPLAY_WIDTH;
   logic [DW-1:0]               csr_data = '0;

   pixel_write_scoreboard_type board = new();
   logic [7:0]            byte_plan [$];
   int                    sent_count = 0;
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   int                    hold_request = 0;
   int                    hold_left = 0;

   rect_pixel_packet_deframer_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_res     (rsp_event_res),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_rgba    (rsp_pixel_rgba),
      .rsp_row_end       (rsp_row_end),
      .rsp_frame_end     (rsp_frame_end),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver stalls: a long hold-off when one is requested, random stalls otherwise.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Every result word taken at an edge is checked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_write({rsp_event_res, rsp_pixel_address, rsp_pixel_rgba,
                            rsp_row_end, rsp_frame_end});
   end

   function automatic bit chance(int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Sends every planned byte; the last one stays offered until the caller lowers valid.
   task automatic send_plan();
      logic [7:0] b;
      while (byte_plan.size() > 0) begin
         b = byte_plan.pop_front();
         while (chance(send_idle_pct)) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data_byte <= b;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         board.take_byte(b);
         sent_count++;
      end
   endtask

   // Stops sending and waits until every predicted word has come out.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_writes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [DW-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      if (idx == rpdf_pkg::REG_DISPLAY_WIDTH) board.disp_w = val;
      else board.disp_h = val;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void set_idling(int mode);
      send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 63 : 0;
      recv_stall_pct = (mode == 0) ? 63 : (mode == 1) ? 32 : 0;
   endfunction

   // Sync word followed by the little-endian rectangle header.
   function automatic void plan_header(int x, int y, int w, int h);
      for (int i = 0; i < 4; i++) byte_plan.push_back(rpdf_pkg::SYNC_WORD[i]);
      byte_plan.push_back(x[7:0]);
      byte_plan.push_back(x[15:8]);
      byte_plan.push_back(y[7:0]);
      byte_plan.push_back(y[15:8]);
      byte_plan.push_back(w[7:0]);
      byte_plan.push_back(w[15:8]);
      byte_plan.push_back(h[7:0]);
      byte_plan.push_back(h[15:8]);
   endfunction

   function automatic void plan_pixels(int n);
      repeat (2 * n) byte_plan.push_back(8'($urandom_range(255)));
   endfunction

   // Mostly well-formed packets of small rectangles, with noise and bad headers mixed in.
   function automatic void plan_random_packet();
      int dw, dh, x, y, w, h, k;
      dw = board.disp_w;
      dh = board.disp_h;
      if (chance(15))
         repeat ($urandom_range(4, 1)) byte_plan.push_back(8'($urandom_range(255)));
      if (chance(10)) begin
         k = $urandom_range(3, 1);
         for (int i = 0; i < k; i++) byte_plan.push_back(rpdf_pkg::SYNC_WORD[i]);
         byte_plan.push_back(8'($urandom_range(255)));
      end
      if (dw == 0 || dh == 0 || chance(25)) begin
         x = 0;
         y = 0;
         w = 1;
         h = 1;
         case ($urandom_range(5))
            0: begin
               x = $urandom_range(65535);
               y = $urandom_range(65535);
               w = $urandom_range(65535);
               h = $urandom_range(65535);
            end
            1: w = 0;
            2: h = 0;
            3: w = MAX_RECT + 1;
            4: x = dw;
            default: y = dh;
         endcase
         plan_header(x, y, w, h);
      end else begin
         w = chance(10) ? $urandom_range(40, 5) : $urandom_range(4, 1);
         h = chance(5) ? $urandom_range(8, 4) : $urandom_range(3, 1);
         if (w > dw) w = dw;
         if (w > MAX_RECT) w = MAX_RECT;
         if (h > dh) h = dh;
         x = chance(20) ? dw - w : $urandom_range(dw - w);
         y = chance(20) ? dh - h : $urandom_range(dh - h);
         plan_header(x, y, w, h);
         plan_pixels(w * h);
      end
   endfunction

   // Main sequence: six display settings, idling changing every two of them.
   initial begin
      int phase_w [6] = '{320, 1, 8191, 0, 4096, 640};
      int phase_h [6] = '{240, 1, 8191, 0, 4096, 480};
      int start;
      int wait_cycles;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 6; p++) begin
         set_idling(p / 2);
         if (p > 0) begin
            drain();
            write_reg(rpdf_pkg::REG_DISPLAY_WIDTH, DW'(phase_w[p]));
            write_reg(rpdf_pkg::REG_DISPLAY_HEIGHT, DW'(phase_h[p]));
         end
         start = sent_count;
         if (p == 0) begin
            // Broken sync with a repeated first byte, then a corner rectangle in
            // black and white, then a header of zero width.
            byte_plan.push_back(rpdf_pkg::SYNC_WORD[0]);
            byte_plan.push_back(rpdf_pkg::SYNC_WORD[0]);
            byte_plan.push_back(rpdf_pkg::SYNC_WORD[1]);
            byte_plan.push_back(8'h5a);
            plan_header(318, 239, 2, 1);
            byte_plan.push_back(8'h00);
            byte_plan.push_back(8'h00);
            byte_plan.push_back(8'hff);
            byte_plan.push_back(8'hff);
            plan_header(0, 0, 0, 1);
            send_plan();
            // A long receiver hold-off while a big rectangle streams in.
            plan_header(0, 0, 64, 2);
            plan_pixels(128);
            hold_request = 300;
            send_plan();
         end
         if (p == 4) begin
            // The stride changes halfway through a rectangle, after a half pixel.
            plan_header(10, 20, 3, 2);
            plan_pixels(3);
            byte_plan.push_back(8'($urandom_range(255)));
            send_plan();
            drain();
            write_reg(rpdf_pkg::REG_DISPLAY_WIDTH, DW'(2000));
            byte_plan.push_back(8'($urandom_range(255)));
            plan_pixels(2);
            send_plan();
            drain();
            write_reg(rpdf_pkg::REG_DISPLAY_WIDTH, DW'(4096));
            // The widest rectangle allowed, on the bottom right of the display.
            plan_header(4096 - MAX_RECT, 4095, MAX_RECT, 1);
            plan_pixels(MAX_RECT);
            send_plan();
         end
         while (sent_count - start < 160) begin
            plan_random_packet();
            send_plan();
         end
      end
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (board.pending_writes.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      board.failures += board.pending_writes.size();
      if (board.failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: rect_pixel_packet_deframer_unit.f
rtl/core/rpdf_pkg.sv
rtl/core/rpdf_front.sv
rtl/core/rpdf_queue.sv
rtl/core/rpdf_back.sv
rtl/core/rect_pixel_packet_deframer_unit.sv
dv/rect_pixel_packet_deframer_unit_tb.sv
